FILE: hw/rtl/smftl_pkg.sv
package smftl_pkg;

	// default geometry
	localparam int CAPACITY_DEF = 4096;
	localparam int SPB_DEF      = 32;

	// fixed field widths
	localparam int CFG_W     = 13;
	localparam int FUNC_W    = 1;
	localparam int LSN_W     = 13;
	localparam int STATUS_W  = 2;
	localparam int PSN_OUT_W = 12;
	localparam int RECL_W    = 8;
	localparam int TOTAL_W   = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_READ  = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD   = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_GC_RD,
		S_GC_EVAL,
		S_GC_END,
		S_FREE_RD,
		S_FREE_EVAL,
		S_MAP_RD,
		S_MAP_WAIT,
		S_OLD_RD,
		S_OLD_WAIT,
		S_NEW_RD,
		S_NEW_WAIT,
		S_DONE
	} fsm_state_t;

endpackage

FILE: hw/rtl/smftl_if.sv
interface smftl_req_if;
	import smftl_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [LSN_W-1:0]  logical_sector;

	modport source(output valid, func, logical_sector, input ready);
	modport sink(input valid, func, logical_sector, output ready);
endinterface

interface smftl_rsp_if;
	import smftl_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic                 mapped;
	logic [PSN_OUT_W-1:0] physical_sector;
	logic [RECL_W-1:0]    blocks_reclaimed;
	logic [TOTAL_W-1:0]   host_writes;
	logic [TOTAL_W-1:0]   block_erases;

	modport source(output valid, status, mapped, physical_sector, blocks_reclaimed,
		host_writes, block_erases, input ready);
	modport sink(input valid, status, mapped, physical_sector, blocks_reclaimed,
		host_writes, block_erases, output ready);
endinterface

FILE: hw/rtl/smftl_ram.sv
module smftl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/sector_mapped_ftl_with_gc.sv
// Sector-mapped flash translation layer with block reclaim. The block keeps a
// logical-to-physical map in one RAM (CAPACITY entries, valid bit plus sector
// number) and the occupied and live bits of each physical block in a second RAM,
// one row per block of SECTORS_PER_BLOCK sectors (a power of two). After reset a
// clearing pass zeroes both RAMs; no request is taken during it, but the size
// register may be written. A write walks the block rows through the single row
// read port: once to reclaim fully occupied blocks that mix live and stale data,
// up to the first block whose last sector is free, then, if in range, once to
// find the lowest free sector; if one is found, a read-modify-write of the map
// and of up to two rows follows. One request is in flight at a time; a finished
// result waits in the output register while the next request is taken.
module sector_mapped_ftl_with_gc #(
	parameter int CAPACITY          = smftl_pkg::CAPACITY_DEF,
	parameter int SECTORS_PER_BLOCK = smftl_pkg::SPB_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [smftl_pkg::CFG_W-1:0] cfg_wdata,
	smftl_req_if.sink                  req,
	smftl_rsp_if.source                rsp
);
	import smftl_pkg::*;

	localparam int SPB   = SECTORS_PER_BLOCK;
	localparam int PSN_W = $clog2(CAPACITY);
	localparam int OFS_W = $clog2(SPB);
	localparam int NBLK  = CAPACITY / SPB;
	localparam int BLK_W = (NBLK > 1) ? $clog2(NBLK) : 1;
	localparam int NB_W  = BLK_W + 1;
	localparam int ROW_W = 2 * SPB;
	localparam int MAP_W = PSN_W + 1;
	localparam int SZ_W  = (PSN_W + 1 > CFG_W) ? PSN_W + 1 : CFG_W;

	// control state
	fsm_state_t         state_q, state_d;
	logic [CFG_W-1:0]   cfg_q;
	logic [PSN_W-1:0]   clr_q;
	logic [NB_W-1:0]    blk_q;
	logic               found_q;
	logic               out_valid_q;
	logic [TOTAL_W-1:0] wtot_q;
	logic [TOTAL_W-1:0] etot_q;

	// per-request context
	logic [FUNC_W-1:0]   func_q;
	logic [LSN_W-1:0]    lsn_q;
	logic [NB_W-1:0]     nblk_q;
	logic                inrange_q;
	logic [PSN_W-1:0]    jpsn_q;
	logic [MAP_W-1:0]    old_q;
	logic [STATUS_W-1:0] status_q;
	logic                mapped_q;
	logic [PSN_W-1:0]    psn_q;
	logic [RECL_W-1:0]   rec_q;

	// output register
	logic [STATUS_W-1:0]  out_status_q;
	logic                 out_mapped_q;
	logic [PSN_OUT_W-1:0] out_psn_q;
	logic [RECL_W-1:0]    out_rec_q;
	logic [TOTAL_W-1:0]   out_wtot_q;
	logic [TOTAL_W-1:0]   out_etot_q;

	// memory ports
	logic             map_we;
	logic [PSN_W-1:0] map_waddr, map_raddr;
	logic [MAP_W-1:0] map_wdata, map_rdata;
	logic             row_we;
	logic [BLK_W-1:0] row_waddr, row_raddr;
	logic [ROW_W-1:0] row_wdata, row_rdata;

	smftl_ram #(.WIDTH(MAP_W), .DEPTH(CAPACITY)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	smftl_ram #(.WIDTH(ROW_W), .DEPTH(NBLK)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	// size register clamped to capacity and cut to whole blocks
	logic [SZ_W-1:0] size_clamp;
	logic [NB_W-1:0] nblk_now;
	logic            inrange_now;

	always_comb begin
		if (SZ_W'(cfg_q) > SZ_W'(CAPACITY)) begin
			size_clamp = SZ_W'(CAPACITY);
		end else begin
			size_clamp = SZ_W'(cfg_q);
		end
		nblk_now    = NB_W'(size_clamp >> OFS_W);
		inrange_now = (SZ_W + 1)'(req.logical_sector) <
			(SZ_W + 1)'({nblk_now, {OFS_W{1'b0}}});
	end

	// row fields of the block just read
	logic [SPB-1:0]   occ, live;
	logic             row_full, row_reclaim, row_has_free;
	logic [OFS_W-1:0] first_free;
	logic [SPB-1:0]   old_mask, new_mask;
	logic             blk_left;

	always_comb begin
		occ          = row_rdata[SPB-1:0];
		live         = row_rdata[ROW_W-1:SPB];
		row_full     = &occ;
		// fully occupied and mixing live with stale sectors
		row_reclaim  = row_full && (|live) && !(&live);
		row_has_free = !row_full;
		first_free   = '0;
		for (int k = SPB - 1; k >= 0; k--) begin
			if (!occ[k]) begin
				first_free = OFS_W'(k);
			end
		end
		old_mask = SPB'(1) << old_q[OFS_W-1:0];
		new_mask = SPB'(1) << jpsn_q[OFS_W-1:0];
		blk_left = blk_q < nblk_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == PSN_W'(CAPACITY - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					state_d = (req.func == FUNC_WRITE) ? S_GC_RD : S_MAP_RD;
				end
			end
			S_GC_RD:     state_d = blk_left ? S_GC_EVAL : S_GC_END;
			S_GC_EVAL:   state_d = occ[SPB-1] ? S_GC_RD : S_GC_END;
			S_GC_END:    state_d = inrange_q ? S_FREE_RD : S_DONE;
			S_FREE_RD:   state_d = blk_left ? S_FREE_EVAL : S_MAP_RD;
			S_FREE_EVAL: state_d = row_has_free ? S_MAP_RD : S_FREE_RD;
			S_MAP_RD:    state_d = S_MAP_WAIT;
			S_MAP_WAIT:  state_d = found_q ? S_OLD_RD : S_DONE;
			S_OLD_RD:    state_d = old_q[PSN_W] ? S_OLD_WAIT : S_NEW_RD;
			S_OLD_WAIT:  state_d = S_NEW_RD;
			S_NEW_RD:    state_d = S_NEW_WAIT;
			S_NEW_WAIT:  state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default:     state_d = S_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		req.ready = (state_q == S_IDLE);
		map_we    = 1'b0;
		map_waddr = lsn_q[PSN_W-1:0];
		map_wdata = {1'b1, jpsn_q};
		map_raddr = lsn_q[PSN_W-1:0];
		row_we    = 1'b0;
		row_waddr = blk_q[BLK_W-1:0];
		row_wdata = {live, live};
		row_raddr = blk_q[BLK_W-1:0];
		unique case (state_q)
			S_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				map_wdata = '0;
				row_we    = (PSN_W + 1)'(clr_q) < (PSN_W + 1)'(NBLK);
				row_waddr = BLK_W'(clr_q);
				row_wdata = '0;
			end
			S_GC_EVAL: begin
				// stale sectors become free, live ones stay
				row_we = row_reclaim;
			end
			S_OLD_RD: begin
				row_raddr = old_q[PSN_W-1:OFS_W];
			end
			S_OLD_WAIT: begin
				row_we    = 1'b1;
				row_waddr = old_q[PSN_W-1:OFS_W];
				row_wdata = {live & ~old_mask, occ};
			end
			S_NEW_RD: begin
				row_raddr = jpsn_q[PSN_W-1:OFS_W];
			end
			S_NEW_WAIT: begin
				row_we    = 1'b1;
				row_waddr = jpsn_q[PSN_W-1:OFS_W];
				row_wdata = {live | new_mask, occ | new_mask};
				map_we    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cfg_q       <= CFG_RESET;
			clr_q       <= '0;
			blk_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			wtot_q      <= '0;
			etot_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + PSN_W'(1);
			end
			if (state_q == S_IDLE && req.valid) begin
				blk_q   <= '0;
				found_q <= 1'b0;
			end
			if (state_q == S_GC_EVAL && occ[SPB-1]) begin
				blk_q <= blk_q + NB_W'(1);
				if (row_reclaim && etot_q != '1) begin
					etot_q <= etot_q + TOTAL_W'(1);
				end
			end
			if (state_q == S_GC_END) begin
				blk_q <= '0;
			end
			if (state_q == S_FREE_EVAL) begin
				if (row_has_free) begin
					found_q <= 1'b1;
				end else begin
					blk_q <= blk_q + NB_W'(1);
				end
			end
			if (state_q == S_NEW_WAIT && wtot_q != '1) begin
				wtot_q <= wtot_q + TOTAL_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request context and result fields
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			func_q    <= req.func;
			lsn_q     <= req.logical_sector;
			nblk_q    <= nblk_now;
			inrange_q <= inrange_now;
			status_q  <= inrange_now ? STAT_OK : STAT_RANGE;
			rec_q     <= '0;
			mapped_q  <= 1'b0;
			psn_q     <= '0;
		end
		if (state_q == S_GC_EVAL && row_reclaim && rec_q != '1) begin
			rec_q <= rec_q + RECL_W'(1);
		end
		if (state_q == S_FREE_RD && !blk_left) begin
			status_q <= STAT_FULL;
		end
		if (state_q == S_FREE_EVAL) begin
			jpsn_q <= PSN_W'({blk_q[BLK_W-1:0], first_free});
		end
		if (state_q == S_MAP_WAIT) begin
			old_q    <= map_rdata;
			mapped_q <= inrange_q && map_rdata[PSN_W];
			psn_q    <= (inrange_q && map_rdata[PSN_W]) ? map_rdata[PSN_W-1:0] : '0;
		end
		if (state_q == S_NEW_WAIT) begin
			mapped_q <= 1'b1;
			psn_q    <= jpsn_q;
		end
		if (out_load) begin
			out_status_q <= status_q;
			out_mapped_q <= mapped_q;
			out_psn_q    <= PSN_OUT_W'(psn_q);
			// reads never reclaim
			out_rec_q    <= (func_q == FUNC_WRITE) ? rec_q : '0;
			out_wtot_q   <= wtot_q;
			out_etot_q   <= etot_q;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.status           = out_status_q;
	assign rsp.mapped           = out_mapped_q;
	assign rsp.physical_sector  = out_psn_q;
	assign rsp.blocks_reclaimed = out_rec_q;
	assign rsp.host_writes      = out_wtot_q;
	assign rsp.block_erases     = out_etot_q;

endmodule

FILE: hw/rtl/smftl_checker.sv
module smftl_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [smftl_pkg::STATUS_W-1:0]  rsp_status,
	input logic                            rsp_mapped,
	input logic [smftl_pkg::PSN_OUT_W-1:0] rsp_psn,
	input logic [smftl_pkg::TOTAL_W-1:0]   rsp_wtot
);
	import smftl_pkg::*;

	// no code beyond no free sector
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status != STAT_BAD)
		else $error("undefined status code");

	// unmapped result reports sector zero
	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_mapped |-> rsp_psn == '0)
		else $error("unmapped result with nonzero sector");

	// out of range never reports a mapping
	a_range_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_RANGE |-> !rsp_mapped)
		else $error("out of range result reports a mapping");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rsp_psn) && $stable(rsp_wtot))
		else $error("stalled result changed");

endmodule

bind sector_mapped_ftl_with_gc smftl_checker u_smftl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_mapped (rsp.mapped),
	.rsp_psn    (rsp.physical_sector),
	.rsp_wtot   (rsp.host_writes)
);

FILE: dv/smftl_tb_chk.sv
module smftl_tb_chk (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [smftl_pkg::CFG_W-1:0] cfg_wdata,
	smftl_req_if.source                 req,
	smftl_rsp_if.sink                   rsp,
	output int                          fail_count,
	output int                          pending
);
	import smftl_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int SPB = SPB_DEF;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic                 mapped;
		logic [PSN_OUT_W-1:0] psn;
		logic [RECL_W-1:0]    recl;
		logic [TOTAL_W-1:0]   writes;
		logic [TOTAL_W-1:0]   erases;
	} ftl_result_t;

	logic           map_ok [CAP];
	int unsigned    map_psn [CAP];
	logic           occ [CAP];
	logic           live [CAP];
	logic [31:0]    wr_total, er_total;
	logic [CFG_W-1:0] size_reg;
	ftl_result_t    want_q [$];

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 1;
	endfunction

	function automatic int unsigned managed();
		int unsigned n;
		n = size_reg;
		if (n > CAP) n = CAP;
		return n - (n % SPB);
	endfunction

	function automatic int unsigned reclaim_blocks(int unsigned n);
		int unsigned got, used, lv;
		got = 0;
		for (int unsigned b = 0; b + SPB <= n; b += SPB) begin
			if (!occ[b+SPB-1]) break;
			used = 0;
			lv = 0;
			for (int k = 0; k < SPB; k++) begin
				used += occ[b+k];
				lv += live[b+k];
			end
			if (used != SPB || lv == 0 || lv == SPB) continue;
			for (int k = 0; k < SPB; k++) occ[b+k] = live[b+k];
			er_total = sat_inc(er_total);
			if (got < 255) got++;
		end
		return got;
	endfunction

	function automatic ftl_result_t translate(logic [FUNC_W-1:0] f, logic [LSN_W-1:0] lsn);
		ftl_result_t r;
		int unsigned n, j, recl;
		logic in_rng, found;
		n = managed();
		in_rng = lsn < n;
		recl = 0;
		r.status = STAT_OK;
		if (f == FUNC_WRITE) begin
			recl = reclaim_blocks(n);
			if (!in_rng) r.status = STAT_RANGE;
			else begin
				found = 0;
				for (j = 0; j < n; j++) if (!occ[j]) begin
					found = 1;
					break;
				end
				if (!found) r.status = STAT_FULL;
				else begin
					if (map_ok[lsn] && map_psn[lsn] < CAP) live[map_psn[lsn]] = 0;
					occ[j] = 1;
					live[j] = 1;
					map_ok[lsn] = 1;
					map_psn[lsn] = j;
					wr_total = sat_inc(wr_total);
				end
			end
		end else if (!in_rng) r.status = STAT_RANGE;
		r.mapped = in_rng && map_ok[lsn];
		r.psn = r.mapped ? PSN_OUT_W'(map_psn[lsn]) : '0;
		r.recl = RECL_W'(recl);
		r.writes = wr_total;
		r.erases = er_total;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		for (int i = 0; i < CAP; i++) begin
			map_ok[i] = 0;
			map_psn[i] = 0;
			occ[i] = 0;
			live[i] = 0;
		end
		wr_total = 0;
		er_total = 0;
		size_reg = CFG_RESET;
	end

	assign pending = want_q.size();

	always @(posedge clk) begin
		ftl_result_t g, w;
		if (arst_n) begin
			if (cfg_we) size_reg <= cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				g = '{rsp.status, rsp.mapped, rsp.physical_sector, rsp.blocks_reclaimed,
					rsp.host_writes, rsp.block_erases};
				if (want_q.size() == 0) report("unexpected result", 0, 0);
				else begin
					w = want_q.pop_front();
					if (g.status !== w.status) report("status", g.status, w.status);
					if (g.mapped !== w.mapped) report("mapped", g.mapped, w.mapped);
					if (g.psn !== w.psn) report("physical_sector", g.psn, w.psn);
					if (g.recl !== w.recl) report("blocks_reclaimed", g.recl, w.recl);
					if (g.writes !== w.writes) report("host_writes", g.writes, w.writes);
					if (g.erases !== w.erases) report("block_erases", g.erases, w.erases);
				end
			end
			if (req.valid && req.ready)
				want_q.push_back(translate(req.func, req.logical_sector));
		end
	end
endmodule

FILE: dv/tb_top.sv
module tb_top;
	import smftl_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	int fail_count, pending;
	int stall_req = 0;

	smftl_req_if req ();
	smftl_rsp_if rsp ();

	sector_mapped_ftl_with_gc u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .rsp(rsp)
	);

	smftl_tb_chk u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .rsp(rsp), .fail_count(fail_count), .pending(pending)
	);

	always #10 clk = ~clk;

	function automatic logic [FUNC_W-1:0] FUNC_LSN_rand();
		return $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
	endfunction

	// one request transfer, random gap first; valid stays up for a following send
	task automatic send(logic [FUNC_W-1:0] f, logic [LSN_W-1:0] lsn);
		int unsigned gap;
		gap = $urandom_range(0, 8);
		if (gap != 0) begin
			req.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1;
		req.func <= f;
		req.logical_sector <= lsn;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// idle point: all results in, plus the write latency for safety
	task automatic drain();
		req.valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (600) @(negedge clk);
	endtask

	task automatic set_size(int unsigned v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= CFG_W'(v);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// receiver: random stall per result, or a long hold-off when asked
	initial begin
		int unsigned gap;
		int stall_seen;
		stall_seen = 0;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_seen != stall_req) begin
				stall_seen = stall_req;
				rsp.ready <= 0;
				repeat (3000) @(negedge clk);
			end
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				rsp.ready <= 0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready <= 1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	// stimulus
	initial begin
		int unsigned lsn;
		req.valid = 0;
		req.func = FUNC_READ;
		req.logical_sector = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1;
		// small size first so the table fills
		cfg_we <= 1;
		cfg_wdata <= CFG_W'(32);
		@(negedge clk);
		cfg_we <= 0;
		// directed: unmapped read, range edges, write then read back
		send(FUNC_READ, LSN_W'(0));
		send(FUNC_READ, 13'h1FFF);
		send(FUNC_WRITE, 13'h1FFF);
		send(FUNC_WRITE, LSN_W'(31));
		send(FUNC_WRITE, LSN_W'(32));
		send(FUNC_READ, LSN_W'(31));
		// fill the block, then overwrites find no free sector and report full
		for (int i = 0; i < 31; i++) send(FUNC_WRITE, LSN_W'(i));
		send(FUNC_WRITE, LSN_W'(0));
		send(FUNC_WRITE, LSN_W'(5));
		send(FUNC_READ, LSN_W'(5));
		// long hold-off: block output stalls, input backs up
		stall_req++;
		for (int i = 0; i < 4; i++) send(FUNC_READ, LSN_W'(i));
		drain();
		// zero size: everything out of range
		set_size(31);
		send(FUNC_WRITE, LSN_W'(0));
		send(FUNC_READ, LSN_W'(0));
		// oversize clamps to capacity
		set_size(13'h1FFF);
		send(FUNC_WRITE, LSN_W'(4095));
		send(FUNC_READ, LSN_W'(4095));
		send(FUNC_WRITE, LSN_W'(4096));
		// random: mostly small region with many overwrites
		set_size(64);
		for (int i = 0; i < 60; i++) begin
			lsn = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 70);
			send($urandom_range(0, 3) != 0 ? FUNC_WRITE : FUNC_READ, LSN_W'(lsn));
		end
		set_size(4096);
		for (int i = 0; i < 30; i++)
			send(FUNC_LSN_rand(), LSN_W'($urandom_range(0, 8191)));
		drain();
		if (fail_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end
endmodule

FILE: filelist.f
hw/rtl/smftl_pkg.sv
hw/rtl/smftl_if.sv
hw/rtl/smftl_ram.sv
hw/rtl/sector_mapped_ftl_with_gc.sv
hw/rtl/smftl_checker.sv
dv/smftl_tb_chk.sv
dv/tb_top.sv
